[sv/irac_pkg.sv]
// Shared types, constants and codes for the interval range accumulator.
// Used by the front end, the back end and the top level; depends on nothing.
package irac_pkg;

    // Store geometry and value format (signed Q16.16 elements)
    localparam int STORE_DEPTH = 4096;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int DELTA_W     = VALUE_W + 1;

    // Field widths fixed by the interface
    localparam int POS_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_APPLY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_APPLIED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BEYOND  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ACCESS  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ONE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT      = 2'd3;

    // Back-end operations
    localparam logic [1:0] OP_DONE  = 2'd0;  // result only, no store access
    localparam logic [1:0] OP_RANGE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POS_W-1:0]          interval_start;
        logic [POS_W-1:0]          interval_end;
        logic signed [VALUE_W-1:0] interval_value;
        logic [INDEX_W-1:0]        element_index;
        logic signed [VALUE_W-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [STATUS_W-1:0]       status;
        logic [ADDR_W-1:0]         lo;
        logic [LEN_W-1:0]          hi;
        logic signed [DELTA_W-1:0] delta;
        logic [ADDR_W-1:0]         idx;
        logic [VALUE_W-1:0]        wdata;
    } cmd_t;

endpackage

[sv/irac_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module irac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/irac_front.sv]
// Front end: configuration registers, request register, classification of
// each request into a back-end command, and a two-entry command queue.
// Depends on irac_pkg.
module irac_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  irac_pkg::in_item_t                 req,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [irac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irac_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               clearing,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output irac_pkg::cmd_t                     cmd
);
    import irac_pkg::*;

    // Configuration
    logic [POS_W-1:0] window_offset_reg;
    logic [LEN_W-1:0] window_length_reg;
    logic             origin_one_reg;
    logic             subtract_reg;

    // Request register
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    in_item_t in_adj;

    // Command queue
    cmd_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               q_full, q_push, q_pop;

    // Classification
    cmd_t             cmd_new;
    logic [LEN_W-1:0] len_eff;
    logic [POS_W-1:0] len_ext;
    logic [POS_W-1:0] pos_s, pos_e;
    logic [POS_W-1:0] diff_s, diff_e, lo_full;
    logic [LEN_W-1:0] lo_w, hi_w;
    logic             in_range;
    logic signed [DELTA_W-1:0] val_ext;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_offset_reg <= '0;
            window_length_reg <= LEN_W'(STORE_DEPTH);
            origin_one_reg    <= 1'b0;
            subtract_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW_OFFSET: window_offset_reg <= cfg_data;
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[LEN_W-1:0];
                CFG_ORIGIN_ONE:    origin_one_reg    <= cfg_data[0];
                CFG_SUBTRACT:      subtract_reg      <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Origin-one starts drop by one on entry; a start of zero stays zero
    always_comb
    begin
        in_adj = req;
        if (origin_one_reg && (req.interval_start != '0))
        begin
            in_adj.interval_start = req.interval_start - POS_W'(1);
        end
    end

    // Request register: held until the queue has room
    assign q_full = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_push = in_valid_reg && !q_full;
    assign full   = clearing || (in_valid_reg && q_full);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (push && !full)
        begin
            in_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            in_item_reg <= in_adj;
        end
    end

    // Classify: window arithmetic and clipping, status for skipped items
    assign len_eff = (window_length_reg > LEN_W'(STORE_DEPTH)) ?
                     LEN_W'(STORE_DEPTH) : window_length_reg;
    assign len_ext = POS_W'(len_eff);
    assign pos_s   = in_item_reg.interval_start;
    assign pos_e   = in_item_reg.interval_end;
    assign diff_s  = pos_s - window_offset_reg;
    assign diff_e  = pos_e - window_offset_reg;
    assign lo_full = (pos_s <= window_offset_reg) ? '0 : diff_s;
    assign val_ext = DELTA_W'(in_item_reg.interval_value);

    always_comb
    begin
        cmd_new        = '0;
        cmd_new.op     = OP_DONE;
        cmd_new.status = STAT_ACCESS;
        cmd_new.idx    = ADDR_W'(in_item_reg.element_index);
        cmd_new.wdata  = in_item_reg.write_data;
        cmd_new.delta  = subtract_reg ? -val_ext : val_ext;
        in_range       = 1'b0;
        lo_w           = '0;
        hi_w           = '0;
        case (in_item_reg.kind)
            KIND_APPLY:
            begin
                if (in_item_reg.interval_value == '0)
                begin
                    cmd_new.status = STAT_ZERO;
                end
                else if (window_offset_reg == '0)
                begin
                    // length-only mode: reject ends past the length
                    if (pos_e > len_ext)
                    begin
                        cmd_new.status = STAT_BEYOND;
                    end
                    else
                    begin
                        in_range = 1'b1;
                        hi_w     = LEN_W'(pos_e);
                        lo_w     = (pos_s >= pos_e) ? hi_w : LEN_W'(pos_s);
                    end
                end
                else
                begin
                    // windowed mode: shift, then clip
                    if ((pos_e <= window_offset_reg) || (lo_full >= len_ext))
                    begin
                        cmd_new.status = STAT_OUTSIDE;
                    end
                    else
                    begin
                        in_range = 1'b1;
                        lo_w     = LEN_W'(lo_full);
                        hi_w     = (diff_e > len_ext) ? len_eff : LEN_W'(diff_e);
                    end
                end
                if (in_range)
                begin
                    cmd_new.status = STAT_APPLIED;
                    if (lo_w < hi_w)
                    begin
                        cmd_new.op = OP_RANGE;
                        cmd_new.lo = lo_w[ADDR_W-1:0];
                        cmd_new.hi = hi_w;
                    end
                end
            end
            KIND_READ:  cmd_new.op = OP_READ;
            KIND_WRITE: cmd_new.op = OP_WRITE;
            default:    cmd_new.op = OP_DONE;
        endcase
    end

    // Command queue
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign q_pop     = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !q_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

[sv/irac_back.sv]
// Back end: store clearing after reset, range update sequencer with a
// read-modify-write pipeline on the value RAM, host access, result queue.
// Depends on irac_pkg and irac_ram.
module irac_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  irac_pkg::cmd_t      cmd,
    output logic                clearing,
    output logic                empty,
    input  logic                pop,
    output irac_pkg::out_item_t result
);
    import irac_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [LEN_W-1:0]          hi_reg, hi_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic                      wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]         wb_addr_reg, wb_addr_next;

    // RAM ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // Saturating sum for the write-back stage
    logic signed [DELTA_W:0]   sum_w;
    logic [VALUE_W-1:0]        sat_w;

    // Result queue
    out_item_t          rq_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] rq_wr_reg, rq_wr_next;
    logic [Q_PTR_W-1:0] rq_rd_reg, rq_rd_next;
    logic [Q_CNT_W-1:0] rq_cnt_reg, rq_cnt_next;
    logic               rq_push, rq_pop;
    out_item_t          rq_item;

    logic start;

    irac_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign clearing = (state_reg == ST_CLEAR);

    // One item at a time; wait for the write-back stage to drain
    assign start = (state_reg == ST_IDLE) && cmd_valid && !wb_valid_reg &&
                   (rq_cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign cmd_ready = start;

    // Saturate element plus delta to the signed value range
    assign sum_w = (DELTA_W + 1)'($signed(ram_rdata)) + (DELTA_W + 1)'(delta_reg);
    always_comb
    begin
        if (sum_w[DELTA_W:VALUE_W-1] == '0 || sum_w[DELTA_W:VALUE_W-1] == '1)
        begin
            sat_w = sum_w[VALUE_W-1:0];
        end
        else if (sum_w[DELTA_W])
        begin
            sat_w = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_w = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        hi_next       = hi_reg;
        delta_next    = delta_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        ram_we        = wb_valid_reg;
        ram_waddr     = wb_addr_reg;
        ram_wdata     = sat_w;
        ram_raddr     = addr_reg;
        rq_push       = 1'b0;
        rq_item       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        OP_RANGE:
                        begin
                            addr_next  = cmd.lo;
                            hi_next    = cmd.hi;
                            delta_next = cmd.delta;
                            state_next = ST_RUN;
                        end
                        OP_READ:
                        begin
                            ram_raddr  = cmd.idx;
                            state_next = ST_READ;
                        end
                        OP_WRITE:
                        begin
                            ram_we         = 1'b1;
                            ram_waddr      = cmd.idx;
                            ram_wdata      = cmd.wdata;
                            rq_push        = 1'b1;
                            rq_item.status = STAT_ACCESS;
                        end
                        default:
                        begin
                            rq_push        = 1'b1;
                            rq_item.status = cmd.status;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // read one element a cycle, write it back the next
                ram_raddr     = addr_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = addr_reg;
                addr_next     = addr_reg + 1'b1;
                if (LEN_W'(addr_reg) + LEN_W'(1) == hi_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_READ:
            begin
                rq_push           = 1'b1;
                rq_item.status    = STAT_ACCESS;
                rq_item.read_data = ram_rdata;
                state_next        = ST_IDLE;
            end
            ST_FIN:
            begin
                rq_push        = 1'b1;
                rq_item.status = STAT_APPLIED;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            wb_valid_reg <= wb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        delta_reg   <= delta_next;
        wb_addr_reg <= wb_addr_next;
    end

    // Result queue
    assign empty  = (rq_cnt_reg == '0);
    assign result = rq_reg[rq_rd_reg];
    assign rq_pop = pop && !empty;

    always_comb
    begin
        rq_wr_next  = rq_push ? rq_wr_reg + 1'b1 : rq_wr_reg;
        rq_rd_next  = rq_pop ? rq_rd_reg + 1'b1 : rq_rd_reg;
        rq_cnt_next = rq_cnt_reg;
        if (rq_push && !rq_pop)
        begin
            rq_cnt_next = rq_cnt_reg + 1'b1;
        end
        else if (rq_pop && !rq_push)
        begin
            rq_cnt_next = rq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            rq_wr_reg  <= rq_wr_next;
            rq_rd_reg  <= rq_rd_next;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_wr_reg] <= rq_item;
        end
    end

endmodule

[sv/interval_range_accumulate_core.sv]
// Channel   Direction  Handshake           Payload
// req       in         push / full         in_item_t (kind, interval, index, data)
// result    out        pop / empty         out_item_t (status, read_data)
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request passes the front-end request register and command queue; the
// back end then reads and writes back each element of an interval in turn
// (one RAM read and one write-back per element). After reset the store is
// cleared one element a cycle, and full stays high throughout the clear.
// Configuration writes are taken at any time.
// Up to two commands and two results queue, so either side may stall.
//
// Top level of the interval range accumulator; depends on irac_pkg,
// irac_front, irac_back and irac_ram.
module interval_range_accumulate_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  irac_pkg::in_item_t             req,
    output logic                           empty,
    input  logic                           pop,
    output irac_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [irac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irac_pkg::CFG_W-1:0]     cfg_data
);
    import irac_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic clearing;

    irac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    irac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // No request taken while the store is being cleared
    a_full_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> full)
        else $error("request accepted during store clear");

    // No command issued to the back end while the store is being cleared
    a_no_cmd_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !cmd_ready)
        else $error("command issued during store clear");

    // Only access results carry read data
    a_read_data_access: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.read_data != '0) |-> result.status == STAT_ACCESS)
        else $error("read data on a non-access result");

    // Status codes stay within the defined set
    a_status_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status <= STAT_ACCESS))
        else $error("undefined status code");

endmodule
